/* sv/olir_pkg.sv */
// Shared codes and types for the ordered list block.
// No dependencies; used by olir_ram, olir_unit and ordered_list_insert_remove.
package olir_pkg;

    localparam int DATA_W = 32;

    typedef logic [1:0] action_t;
    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_REMOVE = 2'd1;
    localparam action_t ACT_DUMP   = 2'd2;

    typedef logic [2:0] status_t;
    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_REMOVED   = 3'd1;
    localparam status_t ST_NOT_FOUND = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_EMPTY     = 3'd4;
    localparam status_t ST_ITEM      = 3'd5;

    // Flags from the shared compare/step unit to the sequencer.
    typedef struct packed {
        logic match;    // read entry equals the search value
        logic at_last;  // pointer addresses the tail entry
        logic more;     // another shift step follows this one
    } unit_flags_t;

endpackage

/* sv/olir_ram.sv */
// Entry storage for the ordered list: one write port, one registered read port.
// Depends on olir_pkg for the data width.
module olir_ram #(
    parameter int DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [$clog2(DEPTH)-1:0]        waddr,
    input  logic [olir_pkg::DATA_W-1:0]     wdata,
    input  logic                            re,
    input  logic [$clog2(DEPTH)-1:0]        raddr,
    output logic [olir_pkg::DATA_W-1:0]     rdata
);

    logic [olir_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/olir_unit.sv */
// Shared compare and pointer-step unit, reused by search, shift and dump.
// Depends on olir_pkg for the data width and the flag struct.
module olir_unit #(
    parameter int AW = 4,
    parameter int CW = 5
) (
    input  logic [AW-1:0]               ptr,
    input  logic [CW-1:0]               count,
    input  logic [olir_pkg::DATA_W-1:0] a,
    input  logic [olir_pkg::DATA_W-1:0] b,
    output logic [AW-1:0]               ptr_inc,
    output olir_pkg::unit_flags_t       flags
);

    logic [CW:0] ptr_ext;
    logic [CW:0] ptr_p1;
    logic [CW:0] ptr_p2;

    assign ptr_ext       = (CW+1)'(ptr);
    assign ptr_p1        = ptr_ext + (CW+1)'(1);
    assign ptr_p2        = ptr_ext + (CW+1)'(2);
    assign ptr_inc       = ptr_p1[AW-1:0];
    assign flags.match   = (a == b);
    assign flags.at_last = (ptr_p1 == (CW+1)'(count));
    assign flags.more    = (ptr_p2 < (CW+1)'(count));

endmodule

/* sv/ordered_list_insert_remove.sv */
// Ordered list of up to CAPACITY signed 32-bit values, kept in insertion order.
// Insert appends at the tail (or reports full) and registers its result at once; remove
// scans the entries (read, compare) up to a match or the tail, shifts the later entries
// down over a match (read, write), then reports; dump reads and emits each entry in turn.
// One request at a time, paced by the one read port of the entry RAM and the shared compare/step unit.
// Reset (rst_n low, async) empties the list; entry contents are not cleared.
// Depends on olir_pkg, olir_ram, olir_unit.
module ordered_list_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [olir_pkg::DATA_W-1:0]     s_axis_tdata,   // [31:0] value
    input  logic [1:0]                      s_axis_tuser,   // [1:0] action
    // result channel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [olir_pkg::DATA_W-1:0]     m_axis_tdata,   // [31:0] item
    output logic [2:0]                      m_axis_tuser,   // [2:0] status
    output logic                            m_axis_tlast
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // One-hot sequencer states
    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_SCAN_RD   = 8'b0000_0010,
        S_SCAN_CMP  = 8'b0000_0100,
        S_SHIFT_RD  = 8'b0000_1000,
        S_SHIFT_WR  = 8'b0001_0000,
        S_FINISH    = 8'b0010_0000,
        S_DUMP_RD   = 8'b0100_0000,
        S_DUMP_EMIT = 8'b1000_0000
    } state_t;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [AW-1:0]               ptr_reg, ptr_next;
    olir_pkg::status_t           fin_reg, fin_next;
    logic [olir_pkg::DATA_W-1:0] val_reg;

    // Output register
    logic                        m_valid_reg, m_valid_next;
    olir_pkg::status_t           m_status_reg;
    logic [olir_pkg::DATA_W-1:0] m_item_reg;
    logic                        m_last_reg;

    logic                        out_free;
    logic                        out_load;
    olir_pkg::status_t           out_status;
    logic [olir_pkg::DATA_W-1:0] out_item;
    logic                        out_last;

    // RAM ports
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [olir_pkg::DATA_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [olir_pkg::DATA_W-1:0] ram_rdata;

    // Shared unit
    logic [AW-1:0]               ptr_inc;
    olir_pkg::unit_flags_t       flags;

    logic                        s_accept;
    logic                        list_full;
    logic                        list_empty;

    olir_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    olir_unit #(
        .AW (AW),
        .CW (CW)
    ) u_unit (
        .ptr     (ptr_reg),
        .count   (count_reg),
        .a       (ram_rdata),
        .b       (val_reg),
        .ptr_inc (ptr_inc),
        .flags   (flags)
    );

    // The output slot is free when empty or being drained this cycle.
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign list_full     = (count_reg == CW'(CAPACITY));
    assign list_empty    = (count_reg == '0);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_item_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        fin_next   = fin_reg;
        ram_we     = 1'b0;
        ram_waddr  = ptr_reg;
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = ptr_reg;
        out_load   = 1'b0;
        out_status = olir_pkg::ST_INSERTED;
        out_item   = '0;
        out_last   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    case (s_axis_tuser)
                        olir_pkg::ACT_INSERT:
                        begin
                            out_load = 1'b1;
                            if (list_full)
                            begin
                                out_status = olir_pkg::ST_FULL;
                            end
                            else
                            begin
                                // Append at the tail
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = s_axis_tdata;
                                count_next = count_reg + CW'(1);
                                out_status = olir_pkg::ST_INSERTED;
                            end
                        end
                        olir_pkg::ACT_REMOVE:
                        begin
                            if (list_empty)
                            begin
                                out_load   = 1'b1;
                                out_status = olir_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_SCAN_RD;
                            end
                        end
                        olir_pkg::ACT_DUMP:
                        begin
                            if (list_empty)
                            begin
                                out_load   = 1'b1;
                                out_status = olir_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            // Unused action code: drop the request
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_SCAN_CMP;
            end

            S_SCAN_CMP:
            begin
                if (flags.match)
                begin
                    // Close the gap unless the match is the tail itself
                    if (flags.at_last)
                    begin
                        fin_next   = olir_pkg::ST_REMOVED;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else if (flags.at_last)
                begin
                    fin_next   = olir_pkg::ST_NOT_FOUND;
                    state_next = S_FINISH;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_SCAN_RD;
                end
            end

            S_SHIFT_RD:
            begin
                // Fetch the successor of the slot being filled
                ram_re     = 1'b1;
                ram_raddr  = ptr_inc;
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                ptr_next  = ptr_inc;
                if (flags.more)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    fin_next   = olir_pkg::ST_REMOVED;
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_status = fin_reg;
                    if (fin_reg == olir_pkg::ST_REMOVED)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            S_DUMP_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_DUMP_EMIT;
            end

            S_DUMP_EMIT:
            begin
                // Hold the read word until the output slot opens
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_status = olir_pkg::ST_ITEM;
                    out_item   = ram_rdata;
                    out_last   = flags.at_last;
                    if (flags.at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        state_next = S_DUMP_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ptr_reg     <= '0;
            fin_reg     <= olir_pkg::ST_NOT_FOUND;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            val_reg <= s_axis_tdata;
        end
        if (out_load)
        begin
            m_status_reg <= out_status;
            m_item_reg   <= out_item;
            m_last_reg   <= out_last;
        end
    end

    // Assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("list count exceeds capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (s_axis_tuser == olir_pkg::ACT_INSERT) && !list_full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_WR) |-> !flags.at_last)
        else $error("shift step writes at or beyond the tail");

    a_item_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (out_status == olir_pkg::ST_ITEM)) |-> !list_empty)
        else $error("entry emitted from an empty list");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("request accepted while an operation is in progress");

endmodule
